FILE: rtl/ibb_pkg.sv
package ibb_pkg;
  localparam int unsigned CFG_W = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PASSES = 2'd3;
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  typedef struct packed {
    logic [7:0] alpha_out;
    logic       last_pixel;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic start_line;   // clear running sum, start a new line
    logic step;         // tied low by the controller and ignored by the datapath
    logic col_phase;    // 0 row pass (src->rowbuf), 1 column pass (rowbuf->src)
  } dp_cmd_t;

  typedef struct packed {
    logic line_done;
  } dp_sts_t;
endpackage

FILE: rtl/ibb_stream_if.sv
interface ibb_stream_if #(parameter int unsigned W = 9);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/ibb_datapath.sv
// one line of a box filter with replicated edges
module ibb_datapath #(
  parameter int unsigned AW = 16,
  parameter int unsigned LW = 9,
  parameter int unsigned RW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ibb_pkg::dp_cmd_t     cmd,
  output ibb_pkg::dp_sts_t     sts,
  input  logic [LW-1:0]        line_len,
  input  logic [RW-1:0]        radius,
  input  logic [AW-1:0]        line_base,
  input  logic [AW-1:0]        stride,
  // memory access request toward top (read address, write)
  output logic [AW-1:0]        rd_addr,
  output logic                 rd_en,
  input  logic [7:0]           rd_data,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [7:0]           wr_data
);
  import ibb_pkg::*;
  localparam int unsigned SW = RW + 10 + 1;
  localparam int unsigned KW = LW + RW + 2;

  // phases of one line
  localparam logic [2:0] P_IDLE = 3'd0, P_PRE = 3'd1, P_PRE_W = 3'd2,
                         P_ADD = 3'd3, P_SUB = 3'd4, P_DIV = 3'd5, P_DONE = 3'd6;
  logic [2:0] ph, ph_next;
  logic signed [KW-1:0] k;        // tap index during presum
  logic [LW-1:0] i;               // output index
  logic [SW-1:0] sum;
  logic [SW-1:0] sum_fold;        // sum with the pending fetch folded in
  logic [SW-1:0] rem;             // quotient digit search remainder
  logic [7:0]    quo;
  logic [3:0]    qbit;
  logic [RW+1:0] diam;
  logic          pend_add, pend_sub;

  function automatic logic [LW-1:0] clampi(input logic signed [KW-1:0] v,
                                           input logic [LW-1:0] n);
    logic [LW-1:0] r;
    if (v < 0) r = '0;
    else if (v >= $signed({{(KW-LW){1'b0}}, n})) r = n - 1'b1;
    else r = v[LW-1:0];
    return r;
  endfunction

  logic signed [KW-1:0] ii_s, r_s;
  logic [LW-1:0] tap;
  always_comb begin
    ii_s = $signed({{(KW-LW){1'b0}}, i});
    r_s  = $signed({{(KW-RW){1'b0}}, radius});
    tap  = '0;
    unique case (ph)
      P_PRE:   tap = clampi(k, line_len);
      P_ADD:   tap = clampi(ii_s + r_s + KW'(1), line_len);
      P_SUB:   tap = clampi(ii_s - r_s, line_len);
      default: tap = '0;
    endcase
  end
  assign rd_addr = line_base + AW'(AW'(tap) * stride);
  assign rd_en   = (ph == P_PRE) || (ph == P_ADD) || (ph == P_SUB);
  assign diam    = {radius, 1'b1};
  assign sts.line_done = (ph == P_DONE);

  // read data is registered: fold previous cycle's fetch in
  assign sum_fold = pend_add ? sum + SW'(rd_data) :
                    (pend_sub ? sum - SW'(rd_data) : sum);

  logic [SW-1:0] trial;
  assign trial = {{(SW-RW-2){1'b0}}, diam} << qbit[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= P_IDLE;
      pend_add <= 1'b0;
      pend_sub <= 1'b0;
    end else begin
      ph <= ph_next;
      pend_add <= (ph == P_ADD) || (ph == P_PRE);
      pend_sub <= (ph == P_SUB);
    end
    sum <= (ph == P_IDLE && cmd.start_line) ? '0 : sum_fold;
    unique case (ph)
      P_IDLE: if (cmd.start_line) begin
        k <= -r_s;
        i <= '0;
      end
      P_PRE: k <= k + KW'(1);
      P_PRE_W: begin
        rem <= sum_fold;
        quo <= '0;
        qbit <= 4'd7;
      end
      P_DIV: begin
        if (trial <= rem) begin
          rem <= rem - trial;
          quo[qbit[2:0]] <= 1'b1;
        end
        qbit <= qbit - 4'd1;
      end
      P_SUB: begin
        i <= i + 1'b1;
      end
      default: ;
    endcase
  end

  logic div_last;
  assign div_last = (ph == P_DIV) && (qbit == 4'd0);
  // write result in the cycle after the final digit decision
  logic div_fin;
  logic [7:0] quo_fin;
  always_ff @(posedge clk) begin
    if (rst) div_fin <= 1'b0;
    else div_fin <= div_last;
    quo_fin <= quo | ((div_last && trial <= rem) ? 8'd1 : 8'd0);
  end
  assign wr_en   = div_fin;
  assign wr_addr = line_base + AW'(AW'(i) * stride);
  assign wr_data = quo_fin;

  always_comb begin
    ph_next = ph;
    unique case (ph)
      P_IDLE:  if (cmd.start_line) ph_next = P_PRE;
      P_PRE:   if (k == r_s) ph_next = P_PRE_W;
      P_PRE_W: ph_next = P_DIV;
      P_DIV:   if (qbit == 4'd0) ph_next = P_ADD;
      P_ADD:   ph_next = P_SUB;
      P_SUB:   ph_next = (i + 1'b1 == line_len) ? P_DONE : P_PRE_W;
      P_DONE:  ph_next = P_IDLE;
      default: ph_next = P_IDLE;
    endcase
  end

  logic unused;
  assign unused = ^{cmd.step, cmd.col_phase};
endmodule

FILE: rtl/ibb_ctrl.sv
// frame sequencer: loads, lines of each pass, fetches
module ibb_ctrl #(
  parameter int unsigned AW = 16,
  parameter int unsigned LW = 9,
  parameter int unsigned PW = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [LW-1:0]    w,
  input  logic [LW-1:0]    h,
  input  logic             blur_on,
  input  logic [PW-1:0]    passes,
  input  logic             in_valid,
  input  logic             in_func,
  output logic             in_ready,
  input  logic             out_slot_free,
  output logic             load_we,
  output logic [AW-1:0]    load_addr,
  output logic             fetch_go,
  output logic [AW-1:0]    fetch_addr,
  output logic             fetch_last,
  output ibb_pkg::dp_cmd_t cmd,
  input  ibb_pkg::dp_sts_t sts,
  output logic [LW-1:0]    line_idx
);
  import ibb_pkg::*;
  localparam logic [1:0] S_IO = 2'd0, S_START = 2'd1, S_LINE = 2'd2;
  logic [1:0]    state;
  logic [AW:0]   lpos, fpos;
  logic          ready_f;
  logic [PW-1:0] pcnt;
  logic          colp;
  logic [AW:0]   total;
  logic          acc;
  logic          run_blur;

  assign total = (AW+1)'(w * h);
  assign in_ready = (state == S_IO) && (in_func == FUNC_LOAD || out_slot_free);
  assign acc = in_valid && in_ready;
  assign load_we = acc && in_func == FUNC_LOAD;
  assign load_addr = lpos[AW] ? '0 : lpos[AW-1:0];
  assign fetch_go = acc && in_func == FUNC_FETCH && ready_f;
  assign fetch_addr = fpos[AW] ? '1 : fpos[AW-1:0];
  assign fetch_last = (fpos + 1'b1 >= total);
  assign cmd.start_line = (state == S_START);
  assign cmd.step = 1'b0;
  assign cmd.col_phase = colp;
  assign run_blur = blur_on && passes != '0;

  logic [AW:0] lnext;
  assign lnext = (lpos[AW] ? '0 : lpos) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IO;
      lpos <= '0;
      fpos <= '0;
      ready_f <= 1'b0;
      pcnt <= '0;
      colp <= 1'b0;
      line_idx <= '0;
    end else begin
      unique case (state)
        S_IO: begin
          if (load_we) begin
            fpos <= '0;
            if (lnext >= total) begin
              lpos <= '0;
              // no blurring: the loaded frame is ready at once
              ready_f <= !run_blur;
              if (run_blur) begin
                state <= S_START;
                pcnt <= '0;
                colp <= 1'b0;
                line_idx <= '0;
              end
            end else begin
              lpos <= lnext;
              ready_f <= 1'b0;
            end
          end else if (fetch_go) begin
            if (fetch_last) begin
              fpos <= '0;
              ready_f <= 1'b0;
            end else fpos <= fpos + 1'b1;
          end
        end
        S_START: state <= S_LINE;
        S_LINE: if (sts.line_done) begin
          if (line_idx + 1'b1 != (colp ? w : h)) begin
            line_idx <= line_idx + 1'b1;
            state <= S_START;
          end else if (!colp) begin
            colp <= 1'b1;
            line_idx <= '0;
            state <= S_START;
          end else if (pcnt + 1'b1 != passes) begin
            pcnt <= pcnt + 1'b1;
            colp <= 1'b0;
            line_idx <= '0;
            state <= S_START;
          end else begin
            ready_f <= 1'b1;
            fpos <= '0;
            state <= S_IO;
          end
        end
        default: state <= S_IO;
      endcase
    end
  end
endmodule

FILE: rtl/iterated_box_blur.sv
// the last load starts the passes if radius and passes are both nonzero; each line has
// a start and a presum over its taps, then per pixel a bit-serial divide and the add and
// subtract fetches. A fetch result goes through the frame-store read register and then
// the output register; a new fetch waits while one is in flight or the output register
// holds an item not taken. rst (synchronous, active high) clears positions, ready flag
// and config to defaults; frame stores are not cleared; unwritten pixels read undefined
module iterated_box_blur #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned MAX_RADIUS = 31,
  parameter int unsigned MAX_PASSES = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  ibb_stream_if.sink                    in_ch,
  ibb_stream_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [ibb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ibb_pkg::CFG_W-1:0]     cfg_data
);
  import ibb_pkg::*;
  localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int unsigned LW = $clog2((MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int unsigned RW = $clog2(MAX_RADIUS + 1);
  localparam int unsigned PW = $clog2(MAX_PASSES + 1);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // config registers, clamped on write
  logic [LW-1:0] w, h;
  logic [RW-1:0] radius;
  logic [PW-1:0] passes;
  logic [8:0] cw;
  logic [4:0] cr;
  logic [2:0] cp;
  assign cw = cfg_data[8:0];
  assign cr = cfg_data[4:0];
  assign cp = cfg_data[2:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      w <= LW'(64 > MAX_WIDTH ? MAX_WIDTH : 64);
      h <= LW'(64 > MAX_HEIGHT ? MAX_HEIGHT : 64);
      radius <= RW'(9 > MAX_RADIUS ? MAX_RADIUS : 9);
      passes <= PW'(3 > MAX_PASSES ? MAX_PASSES : 3);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  w <= (cw == '0) ? LW'(1) : (32'(cw) > MAX_WIDTH ? LW'(MAX_WIDTH) : LW'(cw));
        REG_HEIGHT: h <= (cw == '0) ? LW'(1) :
                         (32'(cw) > MAX_HEIGHT ? LW'(MAX_HEIGHT) : LW'(cw));
        REG_RADIUS: radius <= 32'(cr) > MAX_RADIUS ? RW'(MAX_RADIUS) : RW'(cr);
        REG_PASSES: passes <= 32'(cp) > MAX_PASSES ? PW'(MAX_PASSES) : PW'(cp);
        default: ;
      endcase
    end
  end

  logic in_func;
  logic [7:0] alpha_in;
  assign in_func  = in_ch.data[8];
  assign alpha_in = in_ch.data[7:0];

  // output register; a fetch in flight also holds the slot
  logic out_valid;
  out_item_t out_q;
  logic fetch_d, last_d;
  logic slot_free;
  assign slot_free = !fetch_d && (!out_valid || out_ch.ready);

  logic load_we, fetch_go, fetch_last;
  logic [AW-1:0] load_addr, fetch_addr;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [LW-1:0] line_idx;

  ibb_ctrl #(.AW(AW), .LW(LW), .PW(PW)) u_ctrl (
    .clk, .rst, .w, .h, .blur_on(radius != '0), .passes,
    .in_valid(in_ch.valid), .in_func, .in_ready(in_ch.ready),
    .out_slot_free(slot_free), .load_we, .load_addr, .fetch_go, .fetch_addr,
    .fetch_last, .cmd, .sts, .line_idx
  );

  // row lines start at y*w stride 1, column lines start at x stride w
  logic [AW-1:0] line_base, stride;
  logic [LW-1:0] line_len;
  assign line_base = cmd.col_phase ? AW'(line_idx) : AW'(AW'(line_idx) * AW'(w));
  assign stride    = cmd.col_phase ? AW'(w) : AW'(1);
  assign line_len  = cmd.col_phase ? h : w;

  logic [AW-1:0] dp_rd_addr, dp_wr_addr;
  logic dp_rd_en, dp_we;
  logic [7:0] dp_wd, rd_src, rd_row;

  ibb_datapath #(.AW(AW), .LW(LW), .RW(RW)) u_dp (
    .clk, .rst, .cmd, .sts, .line_len, .radius, .line_base, .stride,
    .rd_addr(dp_rd_addr), .rd_en(dp_rd_en), .rd_data(cmd.col_phase ? rd_row : rd_src),
    .wr_en(dp_we), .wr_addr(dp_wr_addr), .wr_data(dp_wd)
  );

  // frame store (holds source and the result of each column pass)
  logic [7:0] src_mem [DEPTH];
  logic [7:0] row_mem [DEPTH];
  logic [AW-1:0] src_raddr;
  assign src_raddr = fetch_go ? fetch_addr : dp_rd_addr;
  always_ff @(posedge clk) begin
    if (load_we) src_mem[load_addr] <= alpha_in;
    else if (dp_we && cmd.col_phase) src_mem[dp_wr_addr] <= dp_wd;
    rd_src <= src_mem[src_raddr];
  end
  // intermediate store after the row pass
  always_ff @(posedge clk) begin
    if (dp_we && !cmd.col_phase) row_mem[dp_wr_addr] <= dp_wd;
    rd_row <= row_mem[dp_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      fetch_d <= 1'b0;
    end else begin
      fetch_d <= fetch_go;
      if (fetch_d) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
    last_d <= fetch_last;
    if (fetch_d) out_q <= '{alpha_out: rd_src, last_pixel: last_d};
  end
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_q;

  logic unused;
  assign unused = dp_rd_en;
endmodule

FILE: rtl/ibb_checker.sv
module ibb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [8:0] in_data,
  input logic       out_valid,
  input logic       out_ready,
  input logic [8:0] out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");
  // a fetch just before the load may still be on its way out
  a_no_out_after_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_data[8] && !out_valid &&
    !$past(in_valid && in_ready && in_data[8]) |=> ##1 !out_valid)
    else $error("load gave item");
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid) else $error("reset");
endmodule

bind iterated_box_blur ibb_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

FILE: tb/iterated_box_blur_tb.sv
`timescale 1ns / 1ps

module iterated_box_blur_tb;
  import ibb_pkg::*;

  // request layout on the input channel: func above the alpha byte
  typedef struct packed {
    logic       func;
    logic [7:0] alpha;
  } pix_req_t;

  typedef enum int {FETCH_ALL, FETCH_DROP, FETCH_EXTRA} fetch_mode_t;

  localparam int unsigned FRAME_PIX = 256 * 256;
  // longest quiet stretch: the passes over a 256-pixel frame at max radius and passes
  localparam int unsigned IDLE_LIMIT = 1000000;
  localparam int unsigned SETTLE_CYCLES = 64;

  // golden model of the blur engine plus the queue of pixels still owed
  class blur_scoreboard;
    logic [7:0] src_pix [FRAME_PIX];
    logic [7:0] row_pix [FRAME_PIX];
    logic [7:0] col_pix [FRAME_PIX];
    int unsigned width, height, radius, passes;
    int unsigned load_pos, fetch_pos;
    bit frame_ready;
    out_item_t owed[$];
    int errors;

    function new();
      width = 64;
      height = 64;
      radius = 9;
      passes = 3;
      load_pos = 0;
      fetch_pos = 0;
      frame_ready = 0;
      errors = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_WIDTH: width = clamp_dim(v);
        REG_HEIGHT: height = clamp_dim(v);
        REG_RADIUS: radius = v[4:0];
        REG_PASSES: passes = v[2:0];
        default: ;
      endcase
    endfunction

    function int unsigned edge_idx(int k, int unsigned n);
      if (k < 0) return 0;
      if (k >= int'(n)) return n - 1;
      return k;
    endfunction

    // running-sum box filter on one line; col selects rows->columns stage
    function void box_line(bit col, int unsigned base, int unsigned stride,
                           int unsigned n);
      int unsigned sum, diam, a, b;
      sum = 0;
      diam = 2 * radius + 1;
      for (int k = -int'(radius); k <= int'(radius); k++) begin
        a = base + edge_idx(k, n) * stride;
        sum += col ? row_pix[a] : src_pix[a];
      end
      for (int i = 0; i < int'(n); i++) begin
        a = base + edge_idx(i + int'(radius) + 1, n) * stride;
        b = base + edge_idx(i - int'(radius), n) * stride;
        if (col) begin
          col_pix[base + i * stride] = 8'(sum / diam);
          sum = sum + row_pix[a] - row_pix[b];
        end else begin
          row_pix[base + i * stride] = 8'(sum / diam);
          sum = sum + src_pix[a] - src_pix[b];
        end
      end
    endfunction

    function void blur_frame();
      if (radius == 0) return;
      for (int p = 0; p < int'(passes); p++) begin
        for (int y = 0; y < int'(height); y++) box_line(0, y * width, 1, width);
        for (int x = 0; x < int'(width); x++) box_line(1, x, width, height);
        for (int i = 0; i < int'(width * height); i++) src_pix[i] = col_pix[i];
      end
    endfunction

    function void note_input(pix_req_t req);
      out_item_t exp_item;
      int unsigned total;
      total = width * height;
      if (req.func == FUNC_LOAD) begin
        if (frame_ready) begin
          frame_ready = 0;
          fetch_pos = 0;
        end
        if (load_pos >= FRAME_PIX) load_pos = 0;
        src_pix[load_pos] = req.alpha;
        load_pos++;
        if (load_pos >= total) begin
          blur_frame();
          load_pos = 0;
          fetch_pos = 0;
          frame_ready = 1;
        end
      end else if (frame_ready) begin
        if (fetch_pos >= FRAME_PIX) fetch_pos = FRAME_PIX - 1;
        exp_item.alpha_out = src_pix[fetch_pos];
        if (fetch_pos + 1 >= total) begin
          exp_item.last_pixel = 1'b1;
          fetch_pos = 0;
          frame_ready = 0;
        end else begin
          exp_item.last_pixel = 1'b0;
          fetch_pos++;
        end
        owed = {owed, exp_item};
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel: alpha %0d last %0b",
                                   got.alpha_out, got.last_pixel);
        return;
      end
      exp_item = owed.pop_front();
      if (got.alpha_out !== exp_item.alpha_out || got.last_pixel !== exp_item.last_pixel)
      begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: alpha exp %0d got %0d, last exp %0b got %0b",
                   exp_item.alpha_out, got.alpha_out, exp_item.last_pixel,
                   got.last_pixel);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ibb_stream_if #(9) in_ch ();
  ibb_stream_if #(9) out_ch ();

  iterated_box_blur dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  blur_scoreboard sb;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned send_gap_max;   // per-phase idling bounds, 0 gives back-to-back items
  int unsigned recv_gap_max;
  bit hold_off_req;            // asks the receiver for one long stall

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // every input known from time zero
  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    items_sent = 0;
    idle_cycles = 0;
    send_gap_max = 0;
    recv_gap_max = 0;
    hold_off_req = 0;
  end

  // stall watchdog: any handshake on either side resets the count
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("FAIL iterated_box_blur");
        $finish;
      end
    end
  end

  // receiver: random gaps per item, plus the one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    @(negedge clk);
    wait (rst == 1'b0);
    forever begin
      gap = $urandom_range(0, recv_gap_max);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      if (hold_off_req) begin
        // long enough that the output register fills and the input stalls
        out_ch.ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_off_req = 0;
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.data);
      @(negedge clk);
    end
  end

  // one item to the block: gap, offer, wait for acceptance, withdraw
  task automatic send_item(logic func, logic [7:0] alpha);
    pix_req_t req;
    int unsigned gap;
    req.func = func;
    req.alpha = alpha;
    gap = $urandom_range(0, send_gap_max);
    repeat (gap) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data = req;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(req);
    items_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.owed.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // configure, load a whole frame, then read it back in the chosen way
  task automatic run_frame(logic [8:0] w, logic [8:0] h, logic [8:0] r, logic [8:0] p,
                           fetch_mode_t mode, bit long_hold);
    int unsigned total, n_fetch;
    // only touch registers with nothing in flight
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
    write_reg(REG_PASSES, p);
    send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
    recv_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
    total = sb.width * sb.height;
    // stray fetch while nothing ready (or reading a dropped frame's leftover)
    if ($urandom_range(0, 7) == 0) send_item(FUNC_FETCH, 8'($urandom_range(0, 255)));
    for (int i = 0; i < int'(total); i++) begin
      send_item(FUNC_LOAD, pick_alpha());
      // fetch in the middle of loading gets no answer
      if (i + 1 < int'(total) && $urandom_range(0, 29) == 0)
        send_item(FUNC_FETCH, 8'($urandom_range(0, 255)));
    end
    if (long_hold) hold_off_req = 1;
    // at least one fetch, so the passes are over before the next frame
    case (mode)
      FETCH_DROP: n_fetch = (total > 1) ? $urandom_range(1, total - 1) : 1;
      FETCH_EXTRA: n_fetch = total + $urandom_range(1, 3);
      default: n_fetch = total;
    endcase
    for (int i = 0; i < int'(n_fetch); i++) begin
      // sender pause until the pipeline is empty, mid-readout
      if (long_hold && i == int'(n_fetch / 2)) wait_drained();
      send_item(FUNC_FETCH, 8'($urandom_range(0, 255)));
    end
  endtask

  // raw size value: mostly small, sometimes zero
  function automatic logic [8:0] raw_dim(int unsigned hi);
    case ($urandom_range(0, 19))
      0: return 9'd0;
      default: return 9'($urandom_range(1, hi));
    endcase
  endfunction

  initial begin : main_seq
    fetch_mode_t mode;
    int unsigned sel;
    logic [8:0] w, h;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed corners
    run_frame(9'd2, 9'd2, 9'd1, 9'd1, FETCH_ALL, 0);
    run_frame(9'd0, 9'd0, 9'd31, 9'd7, FETCH_EXTRA, 0);        // zero sizes read as one
    run_frame(9'd3, 9'd2, 9'd0, 9'd5, FETCH_ALL, 0);           // radius zero: pass-through
    run_frame(9'd4, 9'd1, 9'd2, 9'd0, FETCH_DROP, 0);          // no passes, frame dropped
    run_frame(9'd3, 9'd3, 9'h1e3, 9'h1fa, FETCH_ALL, 1);       // upper data bits ignored
    run_frame(9'd511, 9'd1, 9'd31, 9'd7, FETCH_ALL, 0);        // width past max
    run_frame(9'd1, 9'd256, 9'd31, 9'd7, FETCH_EXTRA, 0);      // tallest column

    // random frames, mostly full readout of small frames
    while (items_sent < 2000) begin
      sel = $urandom_range(0, 19);
      mode = (sel < 15) ? FETCH_ALL : (sel < 18) ? FETCH_DROP : FETCH_EXTRA;
      case ($urandom_range(0, 19))
        0: begin
          w = 9'($urandom_range(256, 511));
          h = 9'($urandom_range(0, 1));
        end
        1: begin
          w = 9'($urandom_range(0, 1));
          h = 9'($urandom_range(256, 511));
        end
        default: begin
          w = raw_dim(24);
          h = raw_dim(12);
        end
      endcase
      run_frame(w, h, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)), mode,
                $urandom_range(0, 9) == 0);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("PASS iterated_box_blur");
    end else begin
      $display("FAIL iterated_box_blur");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/ibb_pkg.sv
rtl/ibb_stream_if.sv
rtl/ibb_datapath.sv
rtl/ibb_ctrl.sv
rtl/iterated_box_blur.sv
rtl/ibb_checker.sv
tb/iterated_box_blur_tb.sv
